// ===== hdl/lsda_cst_pkg.sv =====
// ----------------------------------------------------------------------------
// lsda_cst_pkg
// Shared types and byte constants of the LSDA call-site table writer.
// ----------------------------------------------------------------------------
package lsda_cst_pkg;

  // Byte values of the stream
  localparam logic [7:0] BYTE_OMIT   = 8'hFF;  // LPStart / TType encoding: omitted
  localparam logic [7:0] BYTE_UDATA4 = 8'h03;  // call-site encoding
  localparam logic [7:0] BYTE_ACTION = 8'h01;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam int         ULEB_BITS   = 7;

  // Step counter limits
  localparam int         CNT_W     = 4;
  localparam logic [3:0] HDR_LAST  = 4'd2;   // FF FF 03
  localparam logic [3:0] BODY_LAST = 4'd12;  // 12 word bytes, then the action byte
  localparam logic [3:0] ACT_FIRST = 4'd0;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'b00,
    CMD_CLOSE  = 2'b01,
    CMD_EXCESS = 2'b10
  } cmd_kind_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HDR  = 6'b000010,
    ST_ULEB = 6'b000100,
    ST_BODY = 6'b001000,
    ST_ACT  = 6'b010000,
    ST_ERR  = 6'b100000
  } back_state_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        hdr;   // header goes out ahead of this item
    logic [31:0] pad;
    logic [31:0] len;   // clamped scope length
    logic [31:0] beg;
  } cmd_t;

endpackage

// ===== hdl/lsda_cst_front.sv =====
// ----------------------------------------------------------------------------
// lsda_cst_front
// Accepts items, holds the table state and the scope count, and turns each
// item into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module lsda_cst_front #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_W      = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [COUNT_BITS-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  operation_i,
  input  logic [31:0]           begin_offset_i,
  input  logic [31:0]           end_offset_i,
  input  logic [31:0]           pad_offset_i,
  output lsda_cst_pkg::cmd_t    cmd_o,
  output logic [LEN_W-1:0]      hlen_o
);
  import lsda_cst_pkg::*;

  logic [COUNT_BITS-1:0] scope_count_q;
  logic [COUNT_BITS:0]   seen_q, seen_d;
  logic                  hdr_sent_q, hdr_sent_d;
  logic                  excess;
  logic [32:0]           diff;
  logic [LEN_W-1:0]      count_ext;

  assign excess = seen_q >= {1'b0, scope_count_q};

  // end - begin, clamped at zero when the scope is reversed
  assign diff = {1'b0, end_offset_i} - {1'b0, begin_offset_i};

  // table length = 13 * count
  assign count_ext = LEN_W'(scope_count_q);
  assign hlen_o    = (count_ext << 3) + (count_ext << 2) + count_ext;

  always_comb begin
    cmd_o.beg  = begin_offset_i;
    cmd_o.len  = diff[32] ? 32'd0 : diff[31:0];
    cmd_o.pad  = pad_offset_i;
    cmd_o.hdr  = !hdr_sent_q;
    seen_d     = seen_q;
    hdr_sent_d = hdr_sent_q;
    if (operation_i) begin
      cmd_o.kind = CMD_CLOSE;
      seen_d     = '0;
      hdr_sent_d = 1'b0;
    end else if (excess) begin
      cmd_o.kind = CMD_EXCESS;
      cmd_o.hdr  = 1'b0;
    end else begin
      cmd_o.kind = CMD_RECORD;
      seen_d     = seen_q + 1'b1;
      hdr_sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scope_count_q <= '0;
      seen_q        <= '0;
      hdr_sent_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        scope_count_q <= cfg_data_i;
      end
      if (accept_i) begin
        seen_q     <= seen_d;
        hdr_sent_q <= hdr_sent_d;
      end
    end
  end

endmodule

// ===== hdl/lsda_cst_fifo.sv =====
// ----------------------------------------------------------------------------
// lsda_cst_fifo
// Short command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module lsda_cst_fifo #(
  parameter int WIDTH = 118,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lsda_cst_back.sv =====
// ----------------------------------------------------------------------------
// lsda_cst_back
// Byte sequencer: walks header, ULEB128 length, record body, action table or
// error beat, one byte per cycle into the output register when not stalled.
// ----------------------------------------------------------------------------
module lsda_cst_back #(
  parameter int LEN_W = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  lsda_cst_pkg::cmd_t q_cmd_i,
  input  logic [LEN_W-1:0]   q_hlen_i,
  output logic               q_pop_o,
  input  logic               pop_i,     // output beat taken
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               error_o
);
  import lsda_cst_pkg::*;

  back_state_e      state_q, state_d;
  cmd_kind_e        kind_q, kind_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] hlen_q, hlen_d;
  logic [95:0]      body_q, body_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d, error_q, error_d;
  logic             emit, more, done;
  back_state_e      step_state;
  logic [CNT_W-1:0] step_cnt;
  logic [LEN_W-1:0] step_hlen;
  logic [95:0]      step_body;

  assign empty_o    = !out_valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;
  assign error_o    = error_q;

  assign emit = (state_q != ST_IDLE) && (!out_valid_q || pop_i);
  assign more = |hlen_q[LEN_W-1:ULEB_BITS];
  assign done = emit && last_d;
  assign q_pop_o = q_valid_i && ((state_q == ST_IDLE) || done);

  // byte of the current step and where the walk goes next
  always_comb begin
    step_state = state_q;
    step_cnt   = cnt_q;
    step_hlen  = hlen_q;
    step_body  = body_q;
    byte_d     = BYTE_ZERO;
    last_d     = 1'b0;
    error_d    = 1'b0;

    case (state_q)
      ST_HDR: begin
        byte_d = (cnt_q == HDR_LAST) ? BYTE_UDATA4 : BYTE_OMIT;
        if (cnt_q == HDR_LAST) begin
          step_state = ST_ULEB;
          step_cnt   = '0;
        end else begin
          step_cnt = cnt_q + 1'b1;
        end
      end
      ST_ULEB: begin
        byte_d    = {more, hlen_q[ULEB_BITS-1:0]};
        step_hlen = hlen_q >> ULEB_BITS;
        if (!more) begin
          if (kind_q == CMD_RECORD) begin
            step_state = ST_BODY;
            step_cnt   = '0;
          end else begin
            last_d = 1'b1;  // close of an empty table: header only
          end
        end
      end
      ST_BODY: begin
        if (cnt_q == BODY_LAST) begin
          byte_d = BYTE_ACTION;
          last_d = 1'b1;
        end else begin
          byte_d    = body_q[7:0];
          step_body = body_q >> 8;
          step_cnt  = cnt_q + 1'b1;
        end
      end
      ST_ACT: begin
        if (cnt_q == ACT_FIRST) begin
          byte_d   = BYTE_ACTION;
          step_cnt = cnt_q + 1'b1;
        end else begin
          byte_d = BYTE_ZERO;
          last_d = 1'b1;
        end
      end
      ST_ERR: begin
        byte_d  = BYTE_ZERO;
        last_d  = 1'b1;
        error_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = done ? ST_IDLE : step_state;
    kind_d  = kind_q;
    cnt_d   = step_cnt;
    hlen_d  = step_hlen;
    body_d  = step_body;

    // load the next command right behind the final beat of the current one
    if (q_pop_o) begin
      kind_d = q_cmd_i.kind;
      hlen_d = q_hlen_i;
      body_d = {q_cmd_i.pad, q_cmd_i.len, q_cmd_i.beg};
      cnt_d  = '0;
      if (q_cmd_i.hdr) begin
        state_d = ST_HDR;
      end else begin
        case (q_cmd_i.kind)
          CMD_RECORD: state_d = ST_BODY;
          CMD_CLOSE:  state_d = ST_ACT;
          default:    state_d = ST_ERR;
        endcase
      end
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit || q_pop_o) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit || q_pop_o) begin
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      hlen_q <= hlen_d;
      body_q <= body_d;
    end
    if (emit) begin
      byte_q  <= byte_d;
      last_q  <= last_d;
      error_q <= error_d;
    end
  end

endmodule

// ===== hdl/lsda_call_site_table_writer.sv =====
// ----------------------------------------------------------------------------
// lsda_call_site_table_writer
// Serializes an LSDA call-site table as a byte stream.
// ----------------------------------------------------------------------------
// Set scope_count through the cfg channel before a table starts. Each scope
// record yields 13 bytes (start, clamped length, landing pad as little-endian
// words, then action byte 01); the first record of a table is preceded by the
// header FF FF 03 and the ULEB128 of 13 * scope_count (one to three bytes for
// a 16-bit count, up to one per 7 bits of the COUNT_BITS+4-bit length for
// other widths). A close yields either that header and length, when no
// record came, or the action table 01 00. A record beyond the count yields one
// byte 00 with error set. Output runs at one byte per cycle while pop takes
// each beat; the byte sequencer is the limit. Items are queued in a short
// command queue, so push stays open as earlier items stream, until it is full.
// ----------------------------------------------------------------------------
module lsda_call_site_table_writer #(
  parameter int COUNT_BITS  = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COUNT_BITS-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation_i,
  input  logic [31:0]           begin_offset_i,
  input  logic [31:0]           end_offset_i,
  input  logic [31:0]           pad_offset_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output logic                  error_o
);
  import lsda_cst_pkg::*;

  localparam int LEN_W = (COUNT_BITS + 4 > 8) ? COUNT_BITS + 4 : 8;
  localparam int Q_W   = $bits(cmd_t) + LEN_W;

  logic             accept, pop_beat;
  cmd_t             f_cmd, q_cmd;
  logic [LEN_W-1:0] f_hlen, q_hlen;
  logic             q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign pop_beat    = pop && !empty;

  lsda_cst_front #(
    .COUNT_BITS(COUNT_BITS),
    .LEN_W     (LEN_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .begin_offset_i(begin_offset_i),
    .end_offset_i  (end_offset_i),
    .pad_offset_i  (pad_offset_i),
    .cmd_o         (f_cmd),
    .hlen_o        (f_hlen)
  );

  lsda_cst_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i ({f_hlen, f_cmd}),
    .pop_i  (q_pop),
    .data_o ({q_hlen, q_cmd}),
    .valid_o(q_valid),
    .full_o (full)
  );

  lsda_cst_back #(
    .LEN_W(LEN_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_hlen_i  (q_hlen),
    .q_pop_o   (q_pop),
    .pop_i     (pop_beat),
    .empty_o   (empty),
    .out_byte_o(out_byte_o),
    .last_o    (last_o),
    .error_o   (error_o)
  );

endmodule

// ===== hdl/lsda_cst_checker.sv =====
// ----------------------------------------------------------------------------
// lsda_cst_checker
// Port-level checks of the LSDA call-site table writer, bound to the top.
// ----------------------------------------------------------------------------
module lsda_cst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic       error_o
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_o)
                          && $stable(error_o)))
    else $error("stalled output beat changed");

  // a dropped record is a single closing beat
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> last_o)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (out_byte_o == 8'h00))
    else $error("error beat carries data");

  // the header start byte FF never closes an item
  a_ff_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o && !error_o) |-> (out_byte_o != 8'hFF))
    else $error("FF byte marked last");

endmodule

bind lsda_call_site_table_writer lsda_cst_checker u_lsda_cst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_byte_o(out_byte_o),
  .last_o    (last_o),
  .error_o   (error_o)
);
